### rtl/alid_pkg.sv
// Shared types and codes for the array list insert/delete/search block.
`timescale 1ns / 1ps

package alid_pkg;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_DELETE = 2'd1,
		REQ_SEARCH = 2'd2,
		REQ_NOP    = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_POS   = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		PTR_HOLD,
		PTR_TOP,
		PTR_POS,
		PTR_ZERO,
		PTR_INC,
		PTR_DEC
	} ptr_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_INS_SHIFT,
		S_INS_LAST,
		S_INS_PUT,
		S_DEL_RD,
		S_DEL_CAP,
		S_DEL_SHIFT,
		S_DEL_FIN,
		S_SRCH,
		S_DONE
	} state_t;

	typedef struct packed {
		logic    load_req;
		logic    set_status;
		status_t status;
		ptr_op_t ptr_op;
		logic    rd_en;
		logic    wr_up;
		logic    wr_down;
		logic    wr_put;
		logic    cap_removed;
		logic    cap_found;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		req_kind_t kind;
		logic      ins_bad;
		logic      ins_append;
		logic      full;
		logic      del_bad;
		logic      ptr_at_pos;
		logic      ptr_at_end;
		logic      match;
		logic      out_free;
	} sts_t;

endpackage

### rtl/array_list_insert_delete_search_top.sv
// Walks: an insert that shifts moves entries n-1 down to p up a slot, a delete moves entries
// p+1 to n-1 down a slot (n entries held, p the position), and a search reads from entry 0
// until a hit or entry n-1; rejected and unused requests and appends walk no entries.
// Throughput: one request at a time; the next beat is taken in the cycle after the result
// is loaded into the output register. The walk of one store entry per cycle sets this.
// Reset: count and sum clear to zero; store contents stay undefined, no clearing pass.
`timescale 1ns / 1ps

module array_list_insert_delete_search_top import alid_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         req_type,
	input  logic [4:0]         position,
	input  logic signed [31:0] operand,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic signed [31:0] removed_value,
	output logic [3:0]         found_position,
	output logic [4:0]         entry_count,
	output logic signed [31:0] entry_total
);

	cmd_t cmd;
	sts_t sts;

	alid_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	alid_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.req_type       (req_type),
		.position       (position),
		.operand        (operand),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.removed_value  (removed_value),
		.found_position (found_position),
		.entry_count    (entry_count),
		.entry_total    (entry_total)
	);

endmodule

### rtl/alid_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module alid_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/alid_datapath.sv
// Datapath: request registers, count, sum, walk pointer, entry store and result register.
`timescale 1ns / 1ps

module alid_datapath import alid_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic [1:0]         req_type,
	input  logic [4:0]         position,
	input  logic signed [31:0] operand,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic signed [31:0] removed_value,
	output logic [3:0]         found_position,
	output logic [4:0]         entry_count,
	output logic signed [31:0] entry_total
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > 5) ? CW : 5;

	req_kind_t       kind_q;
	logic [4:0]      pos_q;
	logic [31:0]     opnd_q;
	logic [CW-1:0]   count_q;
	logic [31:0]     total_q;
	logic [CW-1:0]   ptr_q;
	logic [AW-1:0]   raddr_s1;
	logic            rd_v_s1;
	logic [31:0]     rd_data;
	status_t         status_q;
	logic [31:0]     removed_q;
	logic [AW-1:0]   found_q;
	logic            out_valid_q;
	status_t         out_status_q;
	logic [31:0]     out_removed_q;
	logic [AW-1:0]   out_found_q;
	logic [CW-1:0]   out_count_q;
	logic [31:0]     out_total_q;

	logic [XW-1:0]   pos_x;
	logic [XW-1:0]   count_x;
	logic [AW-1:0]   rd_addr;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	logic [31:0]     wr_data;

	assign pos_x   = XW'(pos_q);
	assign count_x = XW'(count_q);
	assign rd_addr = ptr_q[AW-1:0];

	always_comb begin
		sts.kind       = kind_q;
		sts.ins_bad    = pos_x > count_x;
		sts.ins_append = pos_x == count_x;
		sts.full       = count_q == CW'(CAPACITY);
		sts.del_bad    = pos_x >= count_x;
		sts.ptr_at_pos = XW'(ptr_q) == pos_x;
		sts.ptr_at_end = ptr_q == count_q;
		sts.match      = rd_v_s1 && (rd_data == opnd_q);
		sts.out_free   = !out_valid_q || !out_stall;
	end

	// the shift writes land one slot above or below the entry read last cycle
	always_comb begin
		wr_en   = ((cmd.wr_up || cmd.wr_down) && rd_v_s1) || cmd.wr_put;
		wr_data = cmd.wr_put ? opnd_q : rd_data;
		priority if (cmd.wr_put) begin
			wr_addr = AW'(pos_q);
		end else if (cmd.wr_up) begin
			wr_addr = raddr_s1 + AW'(1);
		end else begin
			wr_addr = raddr_s1 - AW'(1);
		end
	end

	alid_ram #(
		.WIDTH (32),
		.DEPTH (CAPACITY)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (cmd.rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			total_q     <= '0;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= cmd.rd_en;
			if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
				total_q <= total_q + opnd_q;
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CW'(1);
				total_q <= total_q - removed_q;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		raddr_s1 <= rd_addr;
		if (cmd.load_req) begin
			kind_q    <= req_kind_t'(req_type);
			pos_q     <= position;
			opnd_q    <= operand;
			status_q  <= ST_OK;
			removed_q <= '0;
			found_q   <= '0;
		end else begin
			if (cmd.set_status) begin
				status_q <= cmd.status;
			end
			if (cmd.cap_removed) begin
				removed_q <= rd_data;
			end
			if (cmd.cap_found) begin
				found_q <= raddr_s1;
			end
		end
		unique case (cmd.ptr_op)
			PTR_HOLD: ptr_q <= ptr_q;
			PTR_TOP:  ptr_q <= count_q - CW'(1);
			PTR_POS:  ptr_q <= CW'(pos_q);
			PTR_ZERO: ptr_q <= '0;
			PTR_INC:  ptr_q <= ptr_q + CW'(1);
			PTR_DEC:  ptr_q <= ptr_q - CW'(1);
			default:  ptr_q <= ptr_q;
		endcase
		if (cmd.out_load) begin
			out_status_q  <= status_q;
			out_removed_q <= removed_q;
			out_found_q   <= found_q;
			out_count_q   <= count_q;
			out_total_q   <= total_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign removed_value  = out_removed_q;
	assign found_position = 4'(out_found_q);
	assign entry_count    = 5'(out_count_q);
	assign entry_total    = out_total_q;

endmodule

### rtl/alid_ctrl.sv
// Controller state machine sequencing insert, delete and search walks.
`timescale 1ns / 1ps

module alid_ctrl import alid_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				unique case (sts.kind)
					REQ_INSERT: begin
						priority if (sts.ins_bad || sts.full) state_d = S_DONE;
						else if (sts.ins_append) state_d = S_INS_PUT;
						else state_d = S_INS_SHIFT;
					end
					REQ_DELETE: state_d = sts.del_bad ? S_DONE : S_DEL_RD;
					REQ_SEARCH: state_d = S_SRCH;
					default:    state_d = S_DONE;
				endcase
			end
			S_INS_SHIFT: begin
				if (sts.ptr_at_pos) state_d = S_INS_LAST;
			end
			S_INS_LAST:  state_d = S_INS_PUT;
			S_INS_PUT:   state_d = S_DONE;
			S_DEL_RD:    state_d = S_DEL_CAP;
			S_DEL_CAP:   state_d = sts.ptr_at_end ? S_DEL_FIN : S_DEL_SHIFT;
			S_DEL_SHIFT: begin
				if (sts.ptr_at_end) state_d = S_DEL_FIN;
			end
			S_DEL_FIN:   state_d = S_DONE;
			S_SRCH: begin
				if (sts.match || sts.ptr_at_end) state_d = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.status   = ST_OK;
		cmd.ptr_op   = PTR_HOLD;
		in_stall     = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall     = 1'b0;
				cmd.load_req = in_valid;
			end
			S_DECODE: begin
				cmd.set_status = 1'b1;
				unique case (sts.kind)
					REQ_INSERT: begin
						priority if (sts.ins_bad) cmd.status = ST_BAD_POS;
						else if (sts.full) cmd.status = ST_FULL;
						else if (!sts.ins_append) cmd.ptr_op = PTR_TOP;
					end
					REQ_DELETE: begin
						if (sts.del_bad) cmd.status = ST_BAD_POS;
						else cmd.ptr_op = PTR_POS;
					end
					REQ_SEARCH: cmd.ptr_op = PTR_ZERO;
					default: cmd.status = ST_OK;
				endcase
			end
			S_INS_SHIFT: begin
				// walk down from the top entry, moving each one up a slot
				cmd.rd_en = 1'b1;
				cmd.wr_up = 1'b1;
				if (!sts.ptr_at_pos) cmd.ptr_op = PTR_DEC;
			end
			S_INS_LAST: cmd.wr_up = 1'b1;
			S_INS_PUT: begin
				cmd.wr_put  = 1'b1;
				cmd.cnt_inc = 1'b1;
			end
			S_DEL_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.ptr_op = PTR_INC;
			end
			S_DEL_CAP: begin
				cmd.cap_removed = 1'b1;
				if (!sts.ptr_at_end) begin
					cmd.rd_en  = 1'b1;
					cmd.ptr_op = PTR_INC;
				end
			end
			S_DEL_SHIFT: begin
				cmd.wr_down = 1'b1;
				if (!sts.ptr_at_end) begin
					cmd.rd_en  = 1'b1;
					cmd.ptr_op = PTR_INC;
				end
			end
			S_DEL_FIN: cmd.cnt_dec = 1'b1;
			S_SRCH: begin
				// check the entry read last cycle before reading the next one
				priority if (sts.match) begin
					cmd.cap_found = 1'b1;
				end else if (sts.ptr_at_end) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_NOT_FOUND;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.ptr_op = PTR_INC;
				end
			end
			S_DONE: cmd.out_load = sts.out_free;
			default: cmd.load_req = 1'b0;
		endcase
	end

endmodule
